[src/gfe_pkg.sv]
package gfe_pkg;

   localparam int CELL_W       = 11;
   localparam int MAX_CELLS    = 1024;
   localparam int IDX_W        = 32;
   localparam int DIV_STEPS    = 4;
   localparam int DIV_STAGES   = IDX_W / DIV_STEPS;
   localparam int DELAY_STAGES = 3;
   localparam int INNER_W      = 21;

   typedef logic [1:0] axis_type;

   typedef enum logic [1:0] {
      REG_DIMENSIONS,
      REG_CELLS_AXIS0,
      REG_CELLS_AXIS1,
      REG_CELLS_AXIS2
   } csr_reg_type;

   typedef struct packed {
      logic              three;
      logic [CELL_W-1:0] n0;
      logic [CELL_W-1:0] n1;
      logic [CELL_W-1:0] n2;
      logic [IDX_W-1:0]  cut0;
      logic [IDX_W-1:0]  cut1;
      logic [IDX_W-1:0]  total;
      logic [IDX_W-1:0]  base1;
      logic [IDX_W-1:0]  base2;
   } cfg_type;

   typedef struct packed {
      logic              err;
      axis_type          nrm;
      logic [CELL_W-1:0] pos_a;
   } side_type;

   // cyclic successor of an axis, over two or three axes
   function automatic axis_type axis_next(axis_type a, logic three);
      axis_type r;
      if (!three) begin
         r = (a == 2'd0) ? 2'd1 : 2'd0;
      end else if (a == 2'd2) begin
         r = 2'd0;
      end else begin
         r = a + 2'd1;
      end
      return r;
   endfunction

   function automatic logic [CELL_W-1:0] cell_count(cfg_type c, axis_type a);
      logic [CELL_W-1:0] r;
      case (a)
         2'd0:    r = c.n0;
         2'd1:    r = c.n1;
         default: r = c.n2;
      endcase
      return r;
   endfunction

endpackage

[src/gfe_cfg.sv]
module gfe_cfg import gfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CELL_W-1:0] csr_wdata,
   output cfg_type           cfg
);

   logic [1:0]        dims_ff;
   logic [CELL_W-1:0] c0_ff, c1_ff, c2_ff;
   logic [CELL_W-1:0] n0, n1, n2;
   logic              three;
   logic [IDX_W-1:0]  w0, w1, w2, v0, v1, v2;

   // derived products, three register levels deep
   logic [IDX_W-1:0] p01_ff, p02_ff, p12_ff, q01_ff, q02_ff, q12_ff, l2d_ff;
   logic [IDX_W-1:0] f0_ff, f1_ff, f2_ff, l0_ff, l1_ff;
   logic [IDX_W-1:0] cut0_ff, cut1_ff, total_ff, base1_ff, base2_ff;
   logic [IDX_W-1:0] cut0_in, cut1_in, total_in, base1_in, base2_in;

   function automatic logic [CELL_W-1:0] clamp_cells(logic [CELL_W-1:0] v);
      logic [CELL_W-1:0] r;
      if (v == '0) begin
         r = CELL_W'(1);
      end else if (v > CELL_W'(MAX_CELLS)) begin
         r = CELL_W'(MAX_CELLS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 2'd3;
         c0_ff   <= CELL_W'(1);
         c1_ff   <= CELL_W'(1);
         c2_ff   <= CELL_W'(1);
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_DIMENSIONS:  dims_ff <= csr_wdata[1:0];
            REG_CELLS_AXIS0: c0_ff   <= csr_wdata;
            REG_CELLS_AXIS1: c1_ff   <= csr_wdata;
            REG_CELLS_AXIS2: c2_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign n0    = clamp_cells(c0_ff);
   assign n1    = clamp_cells(c1_ff);
   assign n2    = clamp_cells(c2_ff);
   assign three = (dims_ff != 2'd2);
   assign w0    = IDX_W'(n0);
   assign w1    = IDX_W'(n1);
   assign w2    = IDX_W'(n2);
   assign v0    = w0 + IDX_W'(1);
   assign v1    = w1 + IDX_W'(1);
   assign v2    = w2 + IDX_W'(1);

   always_comb begin
      if (three) begin
         cut0_in  = f0_ff;
         cut1_in  = f0_ff + f1_ff;
         total_in = f0_ff + f1_ff + f2_ff;
         base1_in = l0_ff;
         base2_in = l0_ff + l1_ff;
      end else begin
         cut0_in  = p01_ff;
         cut1_in  = p01_ff + p01_ff;
         total_in = p01_ff + p01_ff;
         base1_in = l2d_ff;
         base2_in = l2d_ff;
      end
   end

   always_ff @(posedge clock) begin
      p01_ff   <= w0 * w1;
      p02_ff   <= w0 * w2;
      p12_ff   <= w1 * w2;
      q01_ff   <= v0 * v1;
      q02_ff   <= v0 * v2;
      q12_ff   <= v1 * v2;
      l2d_ff   <= w0 * v1;
      f0_ff    <= v0 * p12_ff;
      f1_ff    <= v1 * p02_ff;
      f2_ff    <= v2 * p01_ff;
      l0_ff    <= w0 * q12_ff;
      l1_ff    <= w1 * q02_ff;
      cut0_ff  <= cut0_in;
      cut1_ff  <= cut1_in;
      total_ff <= total_in;
      base1_ff <= base1_in;
      base2_ff <= base2_in;
   end

   always_comb begin
      cfg.three = three;
      cfg.n0    = n0;
      cfg.n1    = n1;
      cfg.n2    = n2;
      cfg.cut0  = cut0_ff;
      cfg.cut1  = cut1_ff;
      cfg.total = total_ff;
      cfg.base1 = base1_ff;
      cfg.base2 = base2_ff;
   end

endmodule

[src/gfe_select.sv]
module gfe_select import gfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [IDX_W-1:0]  in_index,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [IDX_W-1:0]  out_dividend,
   output logic [CELL_W-1:0] out_divisor,
   output side_type          out_side
);

   // leading stages give the derived configuration products time to settle
   logic [DELAY_STAGES-1:0] vld_ff;
   logic [IDX_W-1:0]        idx_ff [DELAY_STAGES];
   logic [DELAY_STAGES:0]   rdy;

   logic                    ovld_ff;
   logic [IDX_W-1:0]        dvd_ff, dvd_in;
   logic [CELL_W-1:0]       dsr_ff, dsr_in;
   side_type                side_ff, side_in;

   assign rdy[DELAY_STAGES] = !ovld_ff || out_ready;
   assign in_ready          = rdy[0];

   for (genvar g = 0; g < DELAY_STAGES; g++) begin : g_delay
      logic             src_vld;
      logic [IDX_W-1:0] src_idx;
      if (g == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_idx = in_index;
      end else begin : g_next
         assign src_vld = vld_ff[g-1];
         assign src_idx = idx_ff[g-1];
      end
      assign rdy[g] = !vld_ff[g] || rdy[g+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            vld_ff[g] <= src_vld;
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[g] && src_vld) begin
            idx_ff[g] <= src_idx;
         end
      end
   end

   always_comb begin
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] below;
      idx           = idx_ff[DELAY_STAGES-1];
      side_in.err   = (idx >= cfg.total);
      side_in.pos_a = '0;
      if (idx < cfg.cut0) begin
         side_in.nrm = 2'd0;
         below       = '0;
      end else if (!cfg.three || idx < cfg.cut1) begin
         side_in.nrm = 2'd1;
         below       = cfg.cut0;
      end else begin
         side_in.nrm = 2'd2;
         below       = cfg.cut1;
      end
      dvd_in = idx - below;
      // normal axis has one more face position in 3D
      dsr_in = cell_count(cfg, side_in.nrm) + CELL_W'(cfg.three);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (rdy[DELAY_STAGES]) begin
         ovld_ff <= vld_ff[DELAY_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[DELAY_STAGES] && vld_ff[DELAY_STAGES-1]) begin
         dvd_ff  <= dvd_in;
         dsr_ff  <= dsr_in;
         side_ff <= side_in;
      end
   end

   assign out_valid    = ovld_ff;
   assign out_dividend = dvd_ff;
   assign out_divisor  = dsr_ff;
   assign out_side     = side_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_divisor != '0)
      else $error("zero divisor leaves select stage");

endmodule

[src/gfe_div.sv]
module gfe_div import gfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [IDX_W-1:0]  in_dividend,
   input  logic [CELL_W-1:0] in_divisor,
   input  side_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [IDX_W-1:0]  out_quotient,
   output logic [CELL_W-1:0] out_remainder,
   output side_type          out_side
);

   // restoring divider, DIV_STEPS quotient bits per stage;
   // work holds unconsumed dividend bits on top, quotient bits shift in below
   logic [DIV_STAGES-1:0] vld_ff;
   logic [IDX_W-1:0]      work_ff [DIV_STAGES];
   logic [CELL_W-1:0]     rem_ff  [DIV_STAGES];
   logic [CELL_W-1:0]     dsr_ff  [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];
   logic [DIV_STAGES:0]   rdy;

   assign rdy[DIV_STAGES] = out_ready;
   assign in_ready        = rdy[0];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic              src_vld;
      logic [IDX_W-1:0]  src_work;
      logic [CELL_W-1:0] src_rem;
      logic [CELL_W-1:0] src_dsr;
      side_type          src_side;
      logic [IDX_W-1:0]  work_in;
      logic [CELL_W-1:0] rem_in;

      if (g == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_work = in_dividend;
         assign src_rem  = '0;
         assign src_dsr  = in_divisor;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[g-1];
         assign src_work = work_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_dsr  = dsr_ff[g-1];
         assign src_side = side_ff[g-1];
      end

      assign rdy[g] = !vld_ff[g] || rdy[g+1];

      always_comb begin
         logic [IDX_W-1:0]  w;
         logic [CELL_W-1:0] r;
         logic [CELL_W:0]   t;
         w = src_work;
         r = src_rem;
         for (int s = 0; s < DIV_STEPS; s++) begin
            t = {r, w[IDX_W-1]};
            w = {w[IDX_W-2:0], 1'b0};
            if (t >= {1'b0, src_dsr}) begin
               t    = t - {1'b0, src_dsr};
               w[0] = 1'b1;
            end
            r = t[CELL_W-1:0];
         end
         work_in = w;
         rem_in  = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            vld_ff[g] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g] && src_vld) begin
            work_ff[g] <= work_in;
            rem_ff[g]  <= rem_in;
            dsr_ff[g]  <= src_dsr;
            side_ff[g] <= src_side;
         end
      end
   end

   assign out_valid     = vld_ff[DIV_STAGES-1];
   assign out_quotient  = work_ff[DIV_STAGES-1];
   assign out_remainder = rem_ff[DIV_STAGES-1];
   assign out_side      = side_ff[DIV_STAGES-1];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid && dsr_ff[DIV_STAGES-1] != '0 |-> out_remainder < dsr_ff[DIV_STAGES-1])
      else $error("remainder not below divisor");

endmodule

[src/gfe_edge.sv]
module gfe_edge import gfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [IDX_W-1:0]  in_quotient,
   input  logic [CELL_W-1:0] in_remainder,
   input  side_type          in_side,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_edge_first,
   output logic [IDX_W-1:0]  rsp_edge_second,
   output logic [IDX_W-1:0]  rsp_edge_third,
   output logic [IDX_W-1:0]  rsp_edge_fourth,
   output logic              rsp_index_error
);

   // stage 1: positions and inner mixed-radix terms
   logic               v1_ff, e1_ff;
   axis_type           m_ff  [2], m_in  [2];
   logic [CELL_W-1:0]  pm_ff [2], pm_in [2];
   logic [INNER_W-1:0] ia_ff [2], ia_in [2];
   logic [INNER_W-1:0] ib_ff [2], ib_in [2];
   // stage 2: scaled offsets and base sums
   logic               v2_ff, e2_ff;
   logic [IDX_W-1:0]   sum_ff [2], sum_in [2];
   logic [IDX_W-1:0]   oa_ff  [2], oa_in  [2];
   logic [IDX_W-1:0]   ob_ff  [2], ob_in  [2];
   // stage 3: result register
   logic               v3_ff, e3_ff;
   logic [IDX_W-1:0]   ed_ff [4], ed_in [4];
   logic               rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || rsp_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      logic [CELL_W-1:0] p [3];
      axis_type          nrm, u, w;
      logic [IDX_W-1:0]  pu, pwa, pwb, nu1, su;
      nrm  = in_side.nrm;
      p[0] = '0;
      p[1] = '0;
      p[2] = '0;
      if (cfg.three) begin
         p[nrm]                                = in_side.pos_a;
         p[axis_next(nrm, 1'b1)]               = in_remainder;
         p[axis_next(axis_next(nrm, 1'b1), 1'b1)] = in_quotient[CELL_W-1:0];
         case (nrm)
            2'd0:    begin m_in[0] = 2'd1; m_in[1] = 2'd2; end
            2'd1:    begin m_in[0] = 2'd0; m_in[1] = 2'd2; end
            default: begin m_in[0] = 2'd0; m_in[1] = 2'd1; end
         endcase
      end else begin
         p[nrm]                  = in_side.pos_a;
         p[axis_next(nrm, 1'b0)] = in_remainder;
         m_in[0] = 2'd0;
         m_in[1] = 2'd1;
      end
      for (int s = 0; s < 2; s++) begin
         u   = axis_next(m_in[s], cfg.three);
         w   = axis_next(u, cfg.three);
         pu  = IDX_W'(p[u]);
         nu1 = IDX_W'(cell_count(cfg, u)) + IDX_W'(1);
         if (cfg.three) begin
            // the line steps along every axis but the face normal
            pwa = IDX_W'(p[w]);
            pwb = IDX_W'(p[w]) + IDX_W'(w != nrm);
            su  = IDX_W'(u != nrm);
         end else begin
            pwa = '0;
            pwb = '0;
            su  = IDX_W'(1);
         end
         pm_in[s] = p[m_in[s]];
         ia_in[s] = INNER_W'(pu + nu1 * pwa);
         ib_in[s] = INNER_W'(pu + su + nu1 * pwb);
      end
   end

   always_comb begin
      logic [IDX_W-1:0] nm, base;
      for (int s = 0; s < 2; s++) begin
         nm = IDX_W'(cell_count(cfg, m_ff[s]));
         case (m_ff[s])
            2'd0:    base = '0;
            2'd1:    base = cfg.base1;
            default: base = cfg.base2;
         endcase
         sum_in[s] = base + IDX_W'(pm_ff[s]);
         oa_in[s]  = nm * IDX_W'(ia_ff[s]);
         ob_in[s]  = nm * IDX_W'(ib_ff[s]);
      end
   end

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         ed_in[2*s]   = e2_ff ? '0 : sum_ff[s] + oa_ff[s];
         ed_in[2*s+1] = e2_ff ? '0 : sum_ff[s] + ob_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         e1_ff <= in_side.err;
         m_ff  <= m_in;
         pm_ff <= pm_in;
         ia_ff <= ia_in;
         ib_ff <= ib_in;
      end
      if (rdy2 && v1_ff) begin
         e2_ff  <= e1_ff;
         sum_ff <= sum_in;
         oa_ff  <= oa_in;
         ob_ff  <= ob_in;
      end
      if (rdy3 && v2_ff) begin
         e3_ff <= e2_ff;
         ed_ff <= ed_in;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_index_error = e3_ff;
   assign rsp_edge_first  = ed_ff[0];
   assign rsp_edge_second = ed_ff[1];
   assign rsp_edge_third  = ed_ff[2];
   assign rsp_edge_fourth = ed_ff[3];

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |->
         rsp_edge_first == '0 && rsp_edge_second == '0 &&
         rsp_edge_third == '0 && rsp_edge_fourth == '0)
      else $error("error result carries edge indices");

   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_index_error |->
         rsp_edge_first != rsp_edge_second && rsp_edge_third != rsp_edge_fourth)
      else $error("parallel lines of a face coincide");

endmodule

[src/grid_face_to_edge_indices_unit.sv]
// channel  | ports                         | direction | transfer
// request  | req_valid/ready, face_index   | in        | valid & ready
// response | rsp_valid/ready, edge_*, err  | out       | valid & ready
// csr      | csr_we, csr_index, csr_wdata  | in        | csr_we, no wait
//
// One request per cycle sustained when the response is not stalled; requests flow through
// select, the two 8-stage divider pipelines (4 quotient bits per stage) and the edge stage.
// Configuration feeds a 3-level product pipeline read 3 stages after entry.
// Reset is synchronous, clears all valid bits and sets the configuration to 3D, one cell.
// A stalled response holds every stage behind it; bubbles are squeezed out.
module grid_face_to_edge_indices_unit import gfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CELL_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [IDX_W-1:0]  req_face_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_edge_first,
   output logic [IDX_W-1:0]  rsp_edge_second,
   output logic [IDX_W-1:0]  rsp_edge_third,
   output logic [IDX_W-1:0]  rsp_edge_fourth,
   output logic              rsp_index_error
);

   cfg_type           cfg;
   logic              s_vld, s_rdy;
   logic [IDX_W-1:0]  s_dvd;
   logic [CELL_W-1:0] s_dsr;
   side_type          s_side;
   logic              d1_vld, d1_rdy;
   logic [IDX_W-1:0]  d1_quo;
   logic [CELL_W-1:0] d1_rem;
   side_type          d1_side;
   side_type          d2_side_in;
   logic [CELL_W-1:0] d2_dsr;
   logic              d2_vld, d2_rdy;
   logic [IDX_W-1:0]  d2_quo;
   logic [CELL_W-1:0] d2_rem;
   side_type          d2_side;

   gfe_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gfe_select u_select (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_index     (req_face_index),
      .out_valid    (s_vld),
      .out_ready    (s_rdy),
      .out_dividend (s_dvd),
      .out_divisor  (s_dsr),
      .out_side     (s_side)
   );

   // first split: position along the normal axis
   gfe_div u_div_a (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s_vld),
      .in_ready      (s_rdy),
      .in_dividend   (s_dvd),
      .in_divisor    (s_dsr),
      .in_side       (s_side),
      .out_valid     (d1_vld),
      .out_ready     (d1_rdy),
      .out_quotient  (d1_quo),
      .out_remainder (d1_rem),
      .out_side      (d1_side)
   );

   always_comb begin
      d2_side_in       = d1_side;
      d2_side_in.pos_a = d1_rem;
      d2_dsr           = cell_count(cfg, axis_next(d1_side.nrm, cfg.three));
   end

   gfe_div u_div_b (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_vld),
      .in_ready      (d1_rdy),
      .in_dividend   (d1_quo),
      .in_divisor    (d2_dsr),
      .in_side       (d2_side_in),
      .out_valid     (d2_vld),
      .out_ready     (d2_rdy),
      .out_quotient  (d2_quo),
      .out_remainder (d2_rem),
      .out_side      (d2_side)
   );

   gfe_edge u_edge (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (d2_vld),
      .in_ready        (d2_rdy),
      .in_quotient     (d2_quo),
      .in_remainder    (d2_rem),
      .in_side         (d2_side),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_first  (rsp_edge_first),
      .rsp_edge_second (rsp_edge_second),
      .rsp_edge_third  (rsp_edge_third),
      .rsp_edge_fourth (rsp_edge_fourth),
      .rsp_index_error (rsp_index_error)
   );

endmodule

[tb/tb.sv]
module tb;
   import gfe_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
      logic [IDX_W-1:0] third;
      logic [IDX_W-1:0] fourth;
      logic             err;
   } edge_set_type;

   // expected bounding lines for each accepted face request
   class edge_scoreboard;
      logic [1:0]   dim_reg;
      logic [10:0]  cells_reg [3];
      edge_set_type pending_edges [$];
      int           errors;
      longint       last_total;

      function new();
         dim_reg = 2'd3;
         for (int i = 0; i < 3; i++) cells_reg[i] = 11'd1;
         errors = 0;
         last_total = 0;
      endfunction

      function void write_reg(csr_reg_type idx, logic [10:0] v);
         case (idx)
            REG_DIMENSIONS:  dim_reg = v[1:0];
            REG_CELLS_AXIS0: cells_reg[0] = v;
            REG_CELLS_AXIS1: cells_reg[1] = v;
            default:         cells_reg[2] = v;
         endcase
      endfunction

      function longint total_faces();
         void'(resolve_face(32'hFFFF_FFFF, 1'b1));
         return last_total;
      endfunction

      function edge_set_type resolve_face(logic [31:0] face, bit total_only = 0);
         longint n [3], fc [3], lc [3], pos [3], edg [4];
         longint total, below, rem, base, a, b, radix, stp;
         int d, nrm, slot, ax;
         bit three;
         edge_set_type r;
         three = (dim_reg != 2'd2);
         d = three ? 3 : 2;
         for (int i = 0; i < 3; i++) begin
            n[i] = cells_reg[i];
            if (n[i] < 1) n[i] = 1;
            if (n[i] > MAX_CELLS) n[i] = MAX_CELLS;
            pos[i] = 0;
         end
         for (int i = 0; i < 4; i++) edg[i] = 0;
         total = 0;
         for (int m = 0; m < d; m++) begin
            fc[m] = 1;
            lc[m] = 1;
            for (int j = 0; j < d; j++) begin
               if (j != m) begin
                  fc[m] *= n[j];
                  lc[m] *= n[j] + 1;
               end else begin
                  fc[m] *= three ? n[j] + 1 : n[j];
                  lc[m] *= n[j];
               end
            end
            total += fc[m];
         end
         last_total = total;
         r = '0;
         if (total_only) return r;
         if (longint'(face) >= total) begin
            r.err = 1'b1;
            return r;
         end
         below = 0;
         nrm = 0;
         while (nrm < d - 1 && below + fc[nrm] <= longint'(face)) begin
            below += fc[nrm];
            nrm++;
         end
         rem = longint'(face) - below;
         for (int j = 0; j < d; j++) begin
            ax = (j + nrm) % d;
            radix = n[ax] + ((three && j == 0) ? 1 : 0);
            pos[ax] = rem % radix;
            rem /= radix;
         end
         slot = 0;
         for (int m = 0; m < d && slot < 4; m++) begin
            if (three && m == nrm) continue;
            base = 0;
            for (int j = 0; j < m; j++) base += lc[j];
            a = 0;
            b = 0;
            for (int k = d - 1; k >= 0; k--) begin
               ax = (k + m) % d;
               radix = n[ax] + ((k != 0) ? 1 : 0);
               if (three) stp = (ax != nrm && k != 0) ? 1 : 0;
               else stp = (k != 0) ? 1 : 0;
               a = a * radix + pos[ax];
               b = b * radix + pos[ax] + stp;
            end
            edg[slot] = a + base;
            edg[slot+1] = b + base;
            slot += 2;
         end
         r.first = edg[0][31:0];
         r.second = edg[1][31:0];
         r.third = edg[2][31:0];
         r.fourth = edg[3][31:0];
         return r;
      endfunction

      function void note_request(logic [31:0] face);
         pending_edges.push_back(resolve_face(face));
      endfunction

      function void check_response(edge_set_type got);
         edge_set_type want;
         if (pending_edges.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending_edges.pop_front();
         if (got.first !== want.first)
            $display("%0t: edge_first exp %0d got %0d", $time, want.first, got.first);
         if (got.second !== want.second)
            $display("%0t: edge_second exp %0d got %0d", $time, want.second, got.second);
         if (got.third !== want.third)
            $display("%0t: edge_third exp %0d got %0d", $time, want.third, got.third);
         if (got.fourth !== want.fourth)
            $display("%0t: edge_fourth exp %0d got %0d", $time, want.fourth, got.fourth);
         if (got.err !== want.err)
            $display("%0t: index_error exp %0b got %0b", $time, want.err, got.err);
         if (got !== want) errors++;
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_we = 0;
   logic [1:0]        csr_index = '0;
   logic [CELL_W-1:0] csr_wdata = '0;
   logic              req_valid = 0;
   logic              req_ready;
   logic [IDX_W-1:0]  req_face_index = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [IDX_W-1:0]  rsp_edge_first, rsp_edge_second, rsp_edge_third, rsp_edge_fourth;
   logic              rsp_index_error;

   grid_face_to_edge_indices_unit u_dut (.*);

   edge_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int quiet_cycles = 0;

   initial forever #1 clock = ~clock;

   // receiver: random stalls, plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_edge_first, rsp_edge_second, rsp_edge_third,
                               rsp_edge_fourth, rsp_index_error});
         if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_off <= 200;
            rsp_ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("grid_face_to_edge_indices_unit regression: fail");
         $finish;
      end
   end

   // leaves the write enable high so writes can follow back to back
   task automatic write_csr(csr_reg_type idx, logic [10:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic send_face(logic [31:0] face);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_face_index <= face;
      do @(posedge clock); while (!req_ready);
      sb.note_request(face);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_edges.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_grid(logic [1:0] dm, logic [10:0] a, logic [10:0] b, logic [10:0] c);
      write_csr(REG_DIMENSIONS, 11'(dm));
      write_csr(REG_CELLS_AXIS0, a);
      write_csr(REG_CELLS_AXIS1, b);
      write_csr(REG_CELLS_AXIS2, c);
      csr_we <= 1'b0;
   endtask

   // mostly valid faces, some near the limit, some out of range
   function automatic logic [31:0] pick_face();
      longint t;
      int r;
      t = sb.total_faces();
      r = $urandom_range(99);
      if (r < 80) return 32'($urandom_range(32'(t - 1), 0));
      if (r < 88) return 32'(t - 1 - $urandom_range(t > 3 ? 3 : 32'(t - 1), 0));
      if (r < 94) return 32'(t + $urandom_range(3));
      return $urandom();
   endfunction

   initial begin
      longint t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset grid: 3D, one cell
      for (int f = 0; f < 5; f++) send_face(32'(f));
      drain();
      set_grid(2'd2, 11'd1024, 11'd1024, 11'd5);
      t = sb.total_faces();
      send_face(32'd0); send_face(32'(t - 1)); send_face(32'(t)); send_face(32'hFFFF_FFFF);
      send_face(32'(t / 2)); send_face(32'(t / 2 - 1));
      drain();
      set_grid(2'd3, 11'd1024, 11'd1024, 11'd1024);
      t = sb.total_faces();
      send_face(32'd0); send_face(32'(t - 1)); send_face(32'hFFFF_FFFF);
      send_face(32'(t / 3)); send_face(32'(t / 3 + 1)); send_face(32'(2 * t / 3));
      drain();
      // clamp cases and odd dimension codes
      set_grid(2'd0, 11'd0, 11'd2047, 11'd1025);
      send_face(32'd1); send_face(32'h5555_5555); send_face(32'hAAAA_AAAA);
      drain();
      set_grid(2'd1, 11'd3, 11'd4, 11'd5);
      send_face(32'd0); send_face(32'd40);
      drain();
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (ph % 5 == 0)
            set_grid(2'($urandom_range(3)), 11'($urandom_range(1, 1024)),
                     11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
         else
            set_grid(2'($urandom_range(3)), 11'($urandom_range(0, 12)),
                     11'($urandom_range(0, 12)), 11'($urandom_range(0, 12)));
         if (ph == 4) hold_trigger = hold_trigger + 1;
         for (int i = 0; i < 115; i++) send_face(pick_face());
         drain();
      end
      if (sb.errors == 0 && sb.pending_edges.size() == 0)
         $display("grid_face_to_edge_indices_unit regression: pass");
      else
         $display("grid_face_to_edge_indices_unit regression: fail");
      $finish;
   end
endmodule
